### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/alir_pkg.sv
`default_nettype none

package alir_pkg;

  // List capacity and widths
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOVE,
    ST_FIN,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic move_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/alir_if.sv
`default_nettype none

interface alir_req_if import alir_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface alir_rsp_if import alir_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     status;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output read_value, output status, output count,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input read_value, input status, input count,
                input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

### rtl/alir_ctrl.sv
`default_nettype none

module alir_ctrl import alir_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.bad ? ST_DONE : ST_MOVE;
      end
      ST_MOVE: begin
        if (status.move_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.setup = 1'b1;
      end
      ST_MOVE: begin
        cmd.step = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/alir_dp.sv
`default_nettype none

module alir_dp import alir_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ctrl_cmd_t                cmd,
  output dp_status_t                    status,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic                          out_status,
  output logic [CNT_W-1:0]              out_count,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Element store
  logic [DATA_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] rd_q;

  // Request and list state
  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  left_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] wsrc_r;
  logic              pend_r;
  logic              first_r;
  logic [DATA_W-1:0] res_r;
  logic              bad_r;

  // Result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_status_r;
  logic [CNT_W-1:0]         out_count_r;

  logic [POS_W-1:0]  pos_m1;
  logic [ADDR_W-1:0] pos_idx;
  logic              is_insert;
  logic              keep_first;
  logic              bad;

  assign pos_m1     = pos_r - POS_W'(1);
  assign pos_idx    = pos_m1[ADDR_W-1:0];
  assign is_insert  = (mode_r == MODE_INSERT);
  assign keep_first = mode_r inside {MODE_READ, MODE_REMOVE};

  // Check the position against the current count
  always_comb begin
    if (is_insert) begin
      bad = (pos_r == '0) || (pos_m1 > cnt_r) || (cnt_r >= DEPTH_C);
    end else begin
      bad = (pos_r == '0) || (pos_r > cnt_r);
    end
  end

  assign status.bad       = bad;
  assign status.move_done = (left_r == '0) && !pend_r;
  assign status.out_free  = !out_valid_r || out_ready;

  // Memory port control
  always_comb begin
    mem_re    = cmd.step && (left_r != '0);
    mem_raddr = src_r;
    mem_we    = 1'b0;
    mem_waddr = is_insert ? wsrc_r + ADDR_W'(1) : wsrc_r - ADDR_W'(1);
    mem_wdata = rd_q;
    if (cmd.step && pend_r && !first_r) begin
      mem_we = 1'b1;
    end else if (cmd.finish && (mode_r inside {MODE_WRITE, MODE_INSERT})) begin
      mem_we    = 1'b1;
      mem_waddr = pos_idx;
      mem_wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // Capture request and set up the move
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    if (cmd.setup) begin
      bad_r <= bad;
      res_r <= '0;
      case (mode_r)
        MODE_INSERT: src_r <= ADDR_W'(cnt_r - CNT_W'(1));
        default:     src_r <= pos_idx;
      endcase
    end else if (mem_re) begin
      src_r  <= is_insert ? src_r - ADDR_W'(1) : src_r + ADDR_W'(1);
      wsrc_r <= src_r;
    end
    if (cmd.step && pend_r && first_r) res_r <= rd_q;
  end

  // Control state of the move and the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      left_r  <= '0;
      pend_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (cmd.setup) begin
        pend_r  <= 1'b0;
        first_r <= keep_first;
        case (mode_r)
          MODE_READ:   left_r <= CNT_W'(1);
          MODE_WRITE:  left_r <= '0;
          default:     left_r <= cnt_r - pos_m1;
        endcase
      end else if (cmd.step) begin
        pend_r <= mem_re;
        if (mem_re) left_r <= left_r - CNT_W'(1);
        if (pend_r) first_r <= 1'b0;
      end
      if (cmd.finish) begin
        case (mode_r)
          MODE_INSERT: cnt_r <= cnt_r + CNT_W'(1);
          MODE_REMOVE: cnt_r <= cnt_r - CNT_W'(1);
          default:     cnt_r <= cnt_r;
        endcase
      end
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= $signed(res_r);
      out_status_r <= bad_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = (out_count_r == '0);
  assign out_is_full    = (out_count_r == DEPTH_C);

endmodule

`default_nettype wire

### rtl/array_list_insert_remove.sv
// Bounded ordered list of 64 signed 32-bit entries, addressed by 1-based
// position. in_req carries one request (mode, position, value); out_rsp
// returns exactly one response per request: the entry read or removed,
// an error status, and the count, empty and full flags after the request.
// Modes: read, overwrite, insert (later entries move up one place) and
// remove (later entries move down one place, removed value returned).
// Both channels use valid/ready; a request is taken when both are high.
// Response time depends on the mode and on n, the number of entries moved
// (0 to 63), and is set by the shift loop, which moves one entry per cycle
// through the store's single read port and single write port.
// One request is in flight at a time; the next request can be taken in the
// cycle after the previous response enters the output register, even while
// it waits.
// If the receiver stalls, the response holds and at most one more request
// is processed, then in_req.ready stays low until the output is taken.
// Synchronous reset empties the list; entry contents are not cleared.
`default_nettype none

module array_list_insert_remove import alir_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  alir_req_if.sink    in_req,
  alir_rsp_if.source  out_rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_req.ready = in_ready;

  // Sequence each request
  alir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, count and response register
  alir_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_req.mode),
    .in_position    (in_req.position),
    .in_value       (in_req.value),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_read_value (out_rsp.read_value),
    .out_status     (out_rsp.status),
    .out_count      (out_rsp.count),
    .out_is_empty   (out_rsp.is_empty),
    .out_is_full    (out_rsp.is_full)
  );

endmodule

`default_nettype wire

### rtl/alir_checker.sv
`default_nettype none
`include "assert_macros.svh"

module alir_checker import alir_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] out_read_value,
  input wire logic                     out_status,
  input wire logic [CNT_W-1:0]         out_count,
  input wire logic                     out_is_empty,
  input wire logic                     out_is_full
);

  // Stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_count))

  // Empty flag follows the count
  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid, out_is_empty == (out_count == '0))

  // Full flag follows the count, which never exceeds capacity
  `ASSERT_IMPL(a_full_flag, clk, rst_n, out_valid, (out_is_full == (out_count == CNT_W'(DEPTH))) && (out_count <= CNT_W'(DEPTH)))

  // Rejected request returns no data
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_status, out_read_value == '0)

endmodule

bind array_list_insert_remove alir_checker u_alir_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_read_value (out_rsp.read_value),
  .out_status     (out_rsp.status),
  .out_count      (out_rsp.count),
  .out_is_empty   (out_rsp.is_empty),
  .out_is_full    (out_rsp.is_full)
);

`default_nettype wire
